// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

endpackage

// ===== hdl/mi3_mul.sv =====
// registered signed multiplier, split into half-width partial products over two stages
module mi3_mul
   import mi3_pkg::*;
#(
   parameter int AW = 64,
   parameter int BW = 64
) (
   input  logic                 clock,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);
   localparam int AH = AW / 2;
   localparam int BH = BW / 2;

   logic [AH-1:0]            a_lo;
   logic signed [AW-AH-1:0]  a_hi;
   logic [BH-1:0]            b_lo;
   logic signed [BW-BH-1:0]  b_hi;
   logic signed [AW+BW-1:0]  pll_ff, plh_ff, phl_ff, phh_ff;
   logic signed [AW+BW-1:0]  p_in;

   assign a_lo = a[AH-1:0];
   assign a_hi = a[AW-1:AH];
   assign b_lo = b[BH-1:0];
   assign b_hi = b[BW-1:BH];

   always_ff @(posedge clock) begin
      pll_ff <= (AW+BW)'($signed({1'b0, a_lo}) * $signed({1'b0, b_lo}));
      plh_ff <= (AW+BW)'($signed({1'b0, a_lo}) * b_hi);
      phl_ff <= (AW+BW)'(a_hi * $signed({1'b0, b_lo}));
      phh_ff <= (AW+BW)'(a_hi * b_hi);
   end

   assign p_in = pll_ff + (plh_ff <<< BH) + (phl_ff <<< AH) + (phh_ff <<< (AH + BH));

   always_ff @(posedge clock) begin
      p <= p_in;
   end
endmodule

// ===== hdl/mi3_div_cell.sv =====
// one restoring division step for nine lanes; hands partial remainders to the next cell
module mi3_div_cell
   import mi3_pkg::*;
#(
   parameter int NW = 128,
   parameter int DW = 128,
   parameter int QW = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   input  logic [DW-1:0]       den_in,
   input  logic [8:0][NW-1:0]  num_in,
   input  logic [8:0][DW:0]    rem_in,
   input  logic [8:0][QW-1:0]  quo_in,
   input  logic [8:0]          neg_in,
   input  logic                sing_in,
   output logic                valid_out,
   output logic [DW-1:0]       den_out,
   output logic [8:0][NW-1:0]  num_out,
   output logic [8:0][DW:0]    rem_out,
   output logic [8:0][QW-1:0]  quo_out,
   output logic [8:0]          neg_out,
   output logic                sing_out
);
   logic [8:0][DW+1:0] trial;
   logic [8:0][DW:0]   rem_in_n;
   logic [8:0][QW-1:0] quo_in_n;
   logic [8:0][NW-1:0] num_in_n;
   logic               valid_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         trial[i] = {rem_in[i], num_in[i][NW-1]} - {2'b00, den_in};
         num_in_n[i] = num_in[i] << 1;
         // top quotient bit is sticky: once set it stays set
         quo_in_n[i] = {quo_in[i][QW-1] | quo_in[i][QW-2], quo_in[i][QW-3:0],
                        ~trial[i][DW+1]};
         if (!trial[i][DW+1]) begin
            rem_in_n[i] = trial[i][DW:0];
         end else begin
            rem_in_n[i] = {rem_in[i][DW-1:0], num_in[i][NW-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      den_out  <= den_in;
      num_out  <= num_in_n;
      rem_out  <= rem_in_n;
      quo_out  <= quo_in_n;
      neg_out  <= neg_in;
      sing_out <= sing_in;
   end

   assign valid_out = valid_ff;
endmodule

// ===== hdl/matrix3x3_inverse.sv =====
// channel | ports                         | dir | handshake
// req     | start, req_m00..req_m22       | in  | start & !busy
// rsp     | rsp_strobe, rsp_r00..rsp_*    | out | one cycle, strobe
//
// One word in per cycle; busy is tied low. Pipeline stages, in order:
// input register, 3 for the cofactors, 2 for the determinant products, 1 for
// divider setup and rounding offset, one divider cell per quotient bit
// (DATA_WIDTH+2 cells, top bit sticky for overflow), 1 for saturation and output.
// The divider cell chain sets latency. Reset clears only the valid chain.
// The receiver cannot stall.
module matrix3x3_inverse
   import mi3_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_m00, req_m01, req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10, req_m11, req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20, req_m21, req_m22,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_r00, rsp_r01, rsp_r02,
   output logic signed [DATA_WIDTH-1:0] rsp_r10, rsp_r11, rsp_r12,
   output logic signed [DATA_WIDTH-1:0] rsp_r20, rsp_r21, rsp_r22,
   output logic                         rsp_singular,
   output logic                         rsp_saturated
);
   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;          // product
   localparam int AW = 2 * W + 1;      // adjugate entry
   localparam int DTW = 3 * W + 2;     // determinant
   localparam int DW = DTW + 1;        // 2|det|
   localparam int QW = W + 2;          // quotient bits kept (top is overflow sticky)
   localparam int SH = 2 * FRAC_BITS + 1;
   localparam int NW = QW + DW;        // numerator bits fed through cells
   localparam int NC = QW;             // number of cells

   assign busy = 1'b0;

   // stage 0: input register
   logic signed [8:0][W-1:0] m_ff;
   logic [3:0]               v_ff;
   always_ff @(posedge clock) begin
      m_ff <= {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
               req_m02, req_m01, req_m00};
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[2:0], start};
   end

   // cofactor products: index pairs a*b - c*d
   localparam int CA [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
   localparam int CB [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
   localparam int CC [9] = '{5, 1, 2, 3, 6, 5, 6, 7, 1};
   localparam int CD [9] = '{7, 8, 4, 8, 2, 0, 4, 0, 3};

   logic signed [8:0][PW-1:0] pa, pb;
   logic signed [8:0][AW-1:0] adj_ff;
   logic signed [8:0][W-1:0]  m2_ff, m3_ff, m4_ff;

   for (genvar i = 0; i < 9; i++) begin : g_cof
      logic signed [2*W-1:0] xa, xb;
      mi3_mul #(.AW(W), .BW(W)) u_a (.clock, .a(m_ff[CA[i]]), .b(m_ff[CB[i]]), .p(xa));
      mi3_mul #(.AW(W), .BW(W)) u_b (.clock, .a(m_ff[CC[i]]), .b(m_ff[CD[i]]), .p(xb));
      assign pa[i] = xa;
      assign pb[i] = xb;
   end

   // m4_ff lines up with adj_ff
   always_ff @(posedge clock) begin
      m2_ff <= m_ff;
      m3_ff <= m2_ff;
      m4_ff <= m3_ff;
      for (int i = 0; i < 9; i++)
         adj_ff[i] <= AW'($signed(pa[i])) - AW'($signed(pb[i]));
   end

   // determinant: m0*adj0 + m1*adj3 + m2*adj6
   logic signed [2:0][W+AW-1:0] dp;
   logic signed [8:0][AW-1:0]   adj2_ff, adj3_ff;
   mi3_mul #(.AW(W), .BW(AW)) u_d0 (.clock, .a(m4_ff[0]), .b(adj_ff[0]), .p(dp[0]));
   mi3_mul #(.AW(W), .BW(AW)) u_d1 (.clock, .a(m4_ff[1]), .b(adj_ff[3]), .p(dp[1]));
   mi3_mul #(.AW(W), .BW(AW)) u_d2 (.clock, .a(m4_ff[2]), .b(adj_ff[6]), .p(dp[2]));

   logic [1:0] va_ff;
   logic signed [DTW-1:0] det;
   assign det = DTW'($signed(dp[0])) + DTW'($signed(dp[1])) + DTW'($signed(dp[2]));

   // adjugate order in model index (row-major) from cofactor slot
   localparam int AI [9] = '{0, 1, 2, 3, 4, 5, 6, 7, 8};

   always_ff @(posedge clock) begin
      adj2_ff <= adj_ff;
      adj3_ff <= adj2_ff;
      if (reset) va_ff <= '0;
      else       va_ff <= {va_ff[0], v_ff[3]};
   end

   // set up the division
   logic                 c_v_ff;
   logic [DW-1:0]        c_den_ff;
   logic [8:0][NW-1:0]   c_num_ff;
   logic [8:0]           c_neg_ff;
   logic                 c_sing_ff;
   logic [DTW-1:0]       dabs;
   assign dabs = det[DTW-1] ? DTW'(-det) : DTW'(det);

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else       c_v_ff <= va_ff[1];
      c_den_ff  <= {dabs, 1'b0};
      c_sing_ff <= (det == '0);
      for (int i = 0; i < 9; i++) begin
         logic [AW-1:0] aa;
         aa = adj3_ff[AI[i]][AW-1] ? AW'(-adj3_ff[AI[i]]) : AW'(adj3_ff[AI[i]]);
         c_neg_ff[i] <= adj3_ff[AI[i]][AW-1] ^ det[DTW-1];
         c_num_ff[i] <= NW'((NW+SH)'(aa) << SH) + NW'(dabs);
      end
   end

   // the top DW numerator bits seed the remainder; a seed that already reaches
   // the divisor means a quotient of 2^QW or more and sets the sticky top bit
   logic [NC:0]                    cv;
   logic [NC:0][DW-1:0]            cden;
   logic [NC:0][8:0][NW-1:0]       cnum;
   logic [NC:0][8:0][DW:0]         crem;
   logic [NC:0][8:0][QW-1:0]       cquo;
   logic [NC:0][8:0]               cneg;
   logic [NC:0]                    csing;

   assign cv[0]    = c_v_ff;
   assign cden[0]  = c_den_ff;
   assign cneg[0]  = c_neg_ff;
   assign csing[0] = c_sing_ff;
   for (genvar i = 0; i < 9; i++) begin : g_seed
      assign crem[0][i] = (DW+1)'(c_num_ff[i] >> QW);
      assign cnum[0][i] = c_num_ff[i] << DW;
      assign cquo[0][i] = {(c_num_ff[i] >> QW) >= NW'(c_den_ff), (QW-1)'(0)};
   end

   for (genvar k = 0; k < NC; k++) begin : g_cell
      mi3_div_cell #(.NW(NW), .DW(DW), .QW(QW)) u_cell (
         .clock, .reset,
         .valid_in(cv[k]), .den_in(cden[k]), .num_in(cnum[k]), .rem_in(crem[k]),
         .quo_in(cquo[k]), .neg_in(cneg[k]), .sing_in(csing[k]),
         .valid_out(cv[k+1]), .den_out(cden[k+1]), .num_out(cnum[k+1]),
         .rem_out(crem[k+1]), .quo_out(cquo[k+1]), .neg_out(cneg[k+1]),
         .sing_out(csing[k+1])
      );
   end

   // saturation and output register
   localparam logic [QW-1:0] LIM = QW'(1) << (W - 1);
   logic [8:0][W-1:0] r_in;
   logic              sat_in;
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 9; i++) begin
         logic [QW-1:0] q;
         logic          big;
         q = cquo[NC][i];
         // sticky top quotient bit: quotient far beyond the limits
         big = q[QW-1];
         if (cneg[NC][i]) begin
            if (big || q > LIM) begin
               r_in[i] = W'(LIM); sat_in = 1'b1;
            end else r_in[i] = W'(-q);
         end else begin
            if (big || q > LIM - 1'b1) begin
               r_in[i] = W'(LIM - 1'b1); sat_in = 1'b1;
            end else r_in[i] = W'(q);
         end
         if (csing[NC]) r_in[i] = '0;
      end
      if (csing[NC]) sat_in = 1'b0;
   end

   logic              o_v_ff;
   logic [8:0][W-1:0] o_r_ff;
   logic              o_sing_ff, o_sat_ff;
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else       o_v_ff <= cv[NC];
      o_r_ff    <= r_in;
      o_sing_ff <= csing[NC];
      o_sat_ff  <= sat_in;
   end

   assign rsp_strobe    = o_v_ff;
   assign rsp_r00 = o_r_ff[0]; assign rsp_r01 = o_r_ff[1]; assign rsp_r02 = o_r_ff[2];
   assign rsp_r10 = o_r_ff[3]; assign rsp_r11 = o_r_ff[4]; assign rsp_r12 = o_r_ff[5];
   assign rsp_r20 = o_r_ff[6]; assign rsp_r21 = o_r_ff[7]; assign rsp_r22 = o_r_ff[8];
   assign rsp_singular  = o_sing_ff;
   assign rsp_saturated = o_sat_ff;
endmodule
